[rtl/sparse_linear_classifier_defines.svh]
// Assertion macros for the classifier RTL.
`ifndef SPARSE_LINEAR_CLASSIFIER_DEFINES_SVH
`define SPARSE_LINEAR_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent check on a given clock, disabled while the given reset is low.
`define SLC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("slc check failed");

// Concurrent check on the block clock and reset.
`define SLC_ASSERT(lbl, prop) `SLC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define SLC_ASSERT_CLK(lbl, clk, rst_n, prop)
`define SLC_ASSERT(lbl, prop)

`endif

`endif

[rtl/slc_pkg.sv]
`default_nettype none

package slc_pkg;

  // Sizes of the stores.
  localparam int FEATURE_DIM  = 1024;
  localparam int MAX_CLASSES  = 16;
  localparam int FIDX_W       = $clog2(FEATURE_DIM);
  localparam int CLS_W        = $clog2(MAX_CLASSES);
  localparam int CNT_W        = $clog2(MAX_CLASSES + 1);
  localparam int WEIGHT_DEPTH = FEATURE_DIM * MAX_CLASSES;
  localparam int WADDR_W      = FIDX_W + CLS_W;

  // Arithmetic widths: Q4.12 operands, Q8.24 products, Q16.24 scores.
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;

  localparam logic signed [VAL_W-1:0] BIAS_SCALE = VAL_W'(4096);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [CNT_W-1:0] BINARY_CLASSES = CNT_W'(2);

  // Configuration register indexes (address bit 2).
  localparam logic [0:0] REG_CLASS_COUNT = 1'b0;
  localparam logic [0:0] REG_BIAS_ENABLE = 1'b1;

  typedef enum logic [1:0] {
    KIND_WEIGHT  = 2'd0,
    KIND_BIAS    = 2'd1,
    KIND_FEATURE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_BIAS,
    ST_DRAIN,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Commands from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic             issue;
    logic             bias_phase;
    logic [CLS_W-1:0] idx;
    logic             scan_init;
    logic             scan_step;
    logic             clear;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/slc_weight_ram.sv]
`default_nettype none

module slc_weight_ram (
  input  wire                             clk_i,
  input  wire                             we_i,
  input  wire  [slc_pkg::WADDR_W-1:0]     waddr_i,
  input  wire  [slc_pkg::VAL_W-1:0]       wdata_i,
  input  wire  [slc_pkg::WADDR_W-1:0]     raddr_i,
  output logic signed [slc_pkg::VAL_W-1:0] rdata_o
);
  import slc_pkg::*;

  logic [VAL_W-1:0] mem_q [WEIGHT_DEPTH];
  logic [VAL_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = $signed(rdata_q);

endmodule

`default_nettype wire

[rtl/slc_mac.sv]
`default_nettype none

`include "sparse_linear_classifier_defines.svh"

module slc_mac (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  slc_pkg::cmd_t              cmd_i,
  input  wire  signed [slc_pkg::VAL_W-1:0] value_i,
  input  wire  signed [slc_pkg::VAL_W-1:0] bias_i,
  input  wire  signed [slc_pkg::VAL_W-1:0] weight_i,
  output logic                             busy_o,
  output logic [slc_pkg::CLS_W-1:0]        best_o,
  output logic signed [slc_pkg::ACC_W-1:0] score_o
);
  import slc_pkg::*;

  logic                     s1_valid_q;
  logic                     s1_bias_q;
  logic [CLS_W-1:0]         s1_idx_q;
  logic signed [VAL_W-1:0]  s1_bias_val_q;
  logic                     s2_valid_q;
  logic [CLS_W-1:0]         s2_idx_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [VAL_W-1:0]  op_a;
  logic signed [VAL_W-1:0]  op_b;
  logic signed [ACC_W-1:0]  acc_q [MAX_CLASSES];
  logic [CLS_W-1:0]         acc_raddr;
  logic signed [ACC_W-1:0]  acc_rd;
  logic signed [ACC_W:0]    sum_w;
  logic signed [ACC_W-1:0]  sat_sum;
  logic [CLS_W-1:0]         best_q;
  logic signed [ACC_W-1:0]  score_q;

  // Stage one tracks the weight read; the bias is sampled alongside it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bias_q     <= cmd_i.bias_phase;
    s1_idx_q      <= cmd_i.idx;
    s1_bias_val_q <= bias_i;
    s2_idx_q      <= s1_idx_q;
    prod_q        <= prod_d;
  end

  // The shared multiplier: value times weight, or bias times 2^12.
  always_comb begin
    op_a   = s1_bias_q ? BIAS_SCALE : value_i;
    op_b   = s1_bias_q ? s1_bias_val_q : weight_i;
    prod_d = op_a * op_b;
  end

  // One accumulator read port, shared by the adder and the scan.
  assign acc_raddr = s2_valid_q ? s2_idx_q : cmd_i.idx;
  assign acc_rd    = acc_q[acc_raddr];

  // Saturating add of the product into the selected accumulator.
  always_comb begin
    sum_w = (ACC_W+1)'(acc_rd) + (ACC_W+1)'(prod_q);
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sat_sum = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_sum = sum_w[ACC_W-1:0];
    end
  end

  // Accumulator bank, cleared after each result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        acc_q[i] <= '0;
      end
    end else if (s2_valid_q) begin
      acc_q[s2_idx_q] <= sat_sum;
    end
  end

  // Running maximum; strict compare keeps the first maximum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q  <= '0;
      score_q <= acc_rd;
    end else if (cmd_i.scan_step && (acc_rd > score_q)) begin
      best_q  <= cmd_i.idx;
      score_q <= acc_rd;
    end
  end

  assign busy_o  = s1_valid_q | s2_valid_q;
  assign best_o  = best_q;
  assign score_o = score_q;

  `SLC_ASSERT(a_issue_not_scan, cmd_i.issue |-> !(cmd_i.scan_init || cmd_i.scan_step))
  `SLC_ASSERT(a_scan_after_drain, (cmd_i.scan_init || cmd_i.scan_step) |-> !busy_o)
  `SLC_ASSERT(a_clear_after_drain, cmd_i.clear |-> !busy_o)
  `SLC_ASSERT(a_stage_order, s2_valid_q |-> $past(s1_valid_q))

endmodule

`default_nettype wire

[rtl/slc_seq.sv]
`default_nettype none

module slc_seq (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  input  wire                        last_i,
  input  wire                        bias_en_i,
  input  wire  [slc_pkg::CNT_W-1:0]  ncls_i,
  input  wire  [slc_pkg::CNT_W-1:0]  nws_i,
  input  wire                        busy_i,
  input  wire                        out_free_i,
  output logic                       idle_o,
  output slc_pkg::cmd_t              cmd_o
);
  import slc_pkg::*;

  state_e           state_q, state_d;
  logic [CLS_W-1:0] cnt_q, cnt_d;
  logic             last_q;
  logic             ws_end;
  logic             cls_end;

  assign ws_end  = ({1'b0, cnt_q} == (nws_i - CNT_W'(1)));
  assign cls_end = ({1'b0, cnt_q} == (ncls_i - CNT_W'(1)));

  // Next state and class counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (ws_end) begin
          cnt_d   = '0;
          state_d = (last_q && bias_en_i) ? ST_BIAS : ST_DRAIN;
        end else begin
          cnt_d = cnt_q + CLS_W'(1);
        end
      end
      ST_BIAS: begin
        if (ws_end) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + CLS_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          if (!last_q) begin
            state_d = ST_IDLE;
          end else if (ncls_i == BINARY_CLASSES) begin
            state_d = ST_EMIT;
          end else begin
            cnt_d   = CLS_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cls_end) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + CLS_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd_o     = '0;
    cmd_o.idx = cnt_q;
    idle_o    = 1'b0;
    case (state_q)
      ST_IDLE:  idle_o = 1'b1;
      ST_ISSUE: cmd_o.issue = 1'b1;
      ST_BIAS: begin
        cmd_o.issue      = 1'b1;
        cmd_o.bias_phase = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.idx       = '0;
        cmd_o.scan_init = !busy_i && last_q;
      end
      ST_SCAN:  cmd_o.scan_step = 1'b1;
      ST_EMIT:  cmd_o.clear = out_free_i;
      default: begin
        idle_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (start_i && idle_o) begin
        last_q <= last_i;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sparse_linear_classifier.sv]
// Sparse linear classifier, Q4.12 inputs and Q16.24 scores. Words on the
// input stream either load a weight (tuser 0), load a bias (tuser 1) or carry
// one feature element (tuser 2); tuser 3 is dropped.
// A feature element runs the classes in use (one for two classes, otherwise
// the clamped class_count) through a single pipelined multiply-accumulate
// unit, one class per cycle, and holds the block until the unit drains. On
// the word marked tlast a bias pass over the same classes follows when
// enabled, then an argmax scan over the classes in use (none for two
// classes), and the result is placed in the output register once that
// register is free, after which the accumulators are zero again.
// The output register lets the next word enter while a result waits.
// Weights and biases read back as garbage until they have been written.
`default_nettype none

module sparse_linear_classifier (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input words.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: feature_index[9:0], class_slot[13:10], value[29:14], zero pad.
  input  wire  [31:0] s_axis_tdata,
  // tuser: kind[1:0].
  input  wire  [1:0]  s_axis_tuser,
  input  wire         s_axis_tlast,
  // Result words.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata: class_index[3:0], best_score[43:4], zero pad.
  output logic [47:0] m_axis_tdata,
  // Configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slc_pkg::*;

  logic                    in_accept;
  logic [FIDX_W-1:0]       in_fidx;
  logic [CLS_W-1:0]        in_slot;
  logic [VAL_W-1:0]        in_value;
  logic                    cfg_write;
  logic [CNT_W-1:0]        class_count_q;
  logic                    bias_en_q;
  logic [CNT_W-1:0]        ncls;
  logic [CNT_W-1:0]        nws;
  logic [FIDX_W-1:0]       fidx_q;
  logic signed [VAL_W-1:0] value_q;
  logic [VAL_W-1:0]        bias_q [MAX_CLASSES];
  logic signed [VAL_W-1:0] weight_rd;
  logic                    idle;
  logic                    busy;
  cmd_t                    cmd;
  logic [CLS_W-1:0]        best;
  logic signed [ACC_W-1:0] score;
  logic                    out_free;
  logic                    out_valid_q;
  logic [CLS_W-1:0]        out_class_q;
  logic [CLS_W-1:0]        out_class_d;
  logic signed [ACC_W-1:0] out_score_q;

  assign in_fidx  = s_axis_tdata[FIDX_W-1:0];
  assign in_slot  = s_axis_tdata[FIDX_W +: CLS_W];
  assign in_value = s_axis_tdata[FIDX_W+CLS_W +: VAL_W];

  assign s_axis_tready = idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CNT_W'(2);
      bias_en_q     <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_CLASS_COUNT: class_count_q <= pwdata[CNT_W-1:0];
        REG_BIAS_ENABLE: bias_en_q     <= pwdata[0];
        default:         bias_en_q     <= bias_en_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CLASS_COUNT: prdata = 32'(class_count_q);
      REG_BIAS_ENABLE: prdata = 32'(bias_en_q);
      default:         prdata = '0;
    endcase
  end

  // Classes in use, clamped to the supported range.
  always_comb begin
    if (class_count_q < BINARY_CLASSES) begin
      ncls = BINARY_CLASSES;
    end else if (class_count_q > CNT_W'(MAX_CLASSES)) begin
      ncls = CNT_W'(MAX_CLASSES);
    end else begin
      ncls = class_count_q;
    end
    nws = (ncls == BINARY_CLASSES) ? CNT_W'(1) : ncls;
  end

  // Feature word held for the whole pass.
  always_ff @(posedge clk_i) begin
    if (in_accept && (s_axis_tuser == KIND_FEATURE)) begin
      fidx_q  <= in_fidx;
      value_q <= $signed(in_value);
    end
  end

  // Bias registers.
  always_ff @(posedge clk_i) begin
    if (in_accept && (s_axis_tuser == KIND_BIAS)) begin
      bias_q[in_slot] <= in_value;
    end
  end

  slc_weight_ram u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && (s_axis_tuser == KIND_WEIGHT)),
    .waddr_i ({in_fidx, in_slot}),
    .wdata_i (in_value),
    .raddr_i ({fidx_q, cmd.idx}),
    .rdata_o (weight_rd)
  );

  slc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept && (s_axis_tuser == KIND_FEATURE)),
    .last_i     (s_axis_tlast),
    .bias_en_i  (bias_en_q),
    .ncls_i     (ncls),
    .nws_i      (nws),
    .busy_i     (busy),
    .out_free_i (out_free),
    .idle_o     (idle),
    .cmd_o      (cmd)
  );

  slc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (value_q),
    .bias_i   ($signed(bias_q[cmd.idx])),
    .weight_i (weight_rd),
    .busy_o   (busy),
    .best_o   (best),
    .score_o  (score)
  );

  // With two classes the sign of the single score decides.
  always_comb begin
    if (ncls == BINARY_CLASSES) begin
      out_class_d = (score > $signed(ACC_W'(0))) ? CLS_W'(0) : CLS_W'(1);
    end else begin
      out_class_d = best;
    end
  end

  // Output register.
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.clear) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.clear) begin
      out_class_q <= out_class_d;
      out_score_q <= score;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_score_q, out_class_q};

endmodule

`default_nettype wire
